// File: design/cqa_pkg.sv
// shared types, widths and codes for the cochran q accumulator
package cqa_pkg;

   localparam int MAX_VARS_DEF = 16;
   localparam int VAR_CAP      = 16;

   localparam int SUM_W  = 24;
   localparam int CASE_W = 20;
   localparam int RSS_W  = 64;
   localparam int CL_W   = 28;
   localparam int CL2_W  = 52;
   localparam int A_W    = 57;
   localparam int B_W    = 56;
   localparam int NUM_W  = 62;
   localparam int NC_W   = 33;
   localparam int FRAC_W = 16;
   localparam int DIV_W  = NUM_W + FRAC_W;
   localparam int Q_W    = 48;

   localparam logic [1:0] CMD_CELL   = 2'd0;
   localparam logic [1:0] CMD_END    = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [1:0] KIND_ROW = 2'd0;
   localparam logic [1:0] KIND_SUM = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   typedef struct packed {
      logic [SUM_W-1:0] miss;
      logic [SUM_W-1:0] hit;
   } sums_type;

   // first member sits in the highest bits
   typedef struct packed {
      logic             saturated;
      logic             q_undefined;
      logic [Q_W-1:0]   q_value;
      logic [SUM_W-1:0] weight_sum;
      logic [1:0]       codes_found;
      logic [31:0]      failure_code;
      logic [31:0]      success_code;
      logic [SUM_W-1:0] miss_total;
      logic [SUM_W-1:0] hit_total;
      logic [3:0]       row_index;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CELL, ST_SQR, ST_RSS, ST_WRD, ST_ROW, ST_SQ,
      ST_MA, ST_MB, ST_NUM, ST_CHK, ST_DIV, ST_SUM, ST_ERR
   } state_type;

endpackage

// File: design/cochran_q_accumulator_top.sv
// cochran q accumulator: sequencer, sums, output register
// Use: cells of cases enter on the req_ channel, one item per handshake.
// req_tuser carries the command: cell, cell that ends its case, or finish.
// A cell passes a sum read, then a write back; a cell that ends its
// case goes on to square and add up the weighted squared row count.
// req_tready is high only while the sequencer is idle.
// Finish walks the variables (read, row result, square), then the products
// and the denominator check, a serial divide (78 quotient bits, skipped
// when the denominator is not positive), then the summary on rsp_.
// Results: one row per variable (kind 0) and a summary (kind 1) with
// rsp_tlast, or a single error result (kind 2) after a third value.
// A stalled rsp_tready holds the sequencer at the next result; the held
// result stays in the output register.
// csr_ writes var_count; it is always ready and meant for idle periods.
// Reset clears all sums and codes and sets var_count to 2; every finish
// clears the sums and codes again, keeping var_count.
module cochran_q_accumulator_top #(
   parameter int MAX_VARS = cqa_pkg::MAX_VARS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // var_index, cell_value, is_missing, case_weight, zero pad
   input  logic [55:0]  req_tdata,
   // command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // row_index, hit_total, miss_total, success_code, failure_code,
   // codes_found, weight_sum, q_value, q_undefined, saturated
   output logic [191:0] rsp_tdata,
   // kind
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data
);

   localparam int VAR_LIM = MAX_VARS < cqa_pkg::VAR_CAP ? MAX_VARS : cqa_pkg::VAR_CAP;
   localparam int AW      = $clog2(VAR_LIM);
   localparam int SW      = cqa_pkg::SUM_W;
   localparam int CHW     = cqa_pkg::CASE_W;
   localparam int RSW     = cqa_pkg::RSS_W;
   localparam int CLW     = cqa_pkg::CL_W;
   localparam int CL2W    = cqa_pkg::CL2_W;
   localparam int AMW     = cqa_pkg::A_W;
   localparam int BMW     = cqa_pkg::B_W;
   localparam int NMW     = cqa_pkg::NUM_W;
   localparam int NCW     = cqa_pkg::NC_W;
   localparam int DVW     = cqa_pkg::DIV_W;
   localparam int QW      = cqa_pkg::Q_W;
   localparam int FW      = cqa_pkg::FRAC_W;

   cqa_pkg::state_type state_ff, state_in;

   logic [4:0]  var_count_ff;
   logic [4:0]  k_eff;

   logic [1:0]  cmd_ff;
   logic [3:0]  idx_ff;
   logic [31:0] val_ff;
   logic        miss_ff;
   logic [15:0] w_ff;

   logic [31:0]    succ_ff, fail_ff;
   logic [1:0]     seen_ff;
   logic [CHW-1:0] case_hit_ff;
   logic [RSW-1:0] rss_ff;
   logic [SW-1:0]  tw_ff;
   logic           bad_ff, sat_ff;

   logic [4:0]      walk_ff;
   logic [CLW-1:0]  cl_ff;
   logic [CL2W-1:0] cl2_ff;
   logic [2*SW-1:0] sq_ff;
   logic [2*CHW-1:0] rsq_ff;
   logic [AMW-1:0]  a_ff;
   logic [BMW-1:0]  b_ff;
   logic [NMW-1:0]  num_ff;
   logic [NCW-1:0]  nc_ff;
   logic            undef_ff;

   logic                  rsp_valid_ff;
   cqa_pkg::rsp_data_type rsp_data_ff;
   cqa_pkg::rsp_data_type rsp_data_in;
   logic [1:0]            rsp_kind_ff;
   logic                  rsp_last_ff;

   cqa_pkg::sums_type rd_sums, wr_sums;
   logic              st_rd_en, st_wr_en, st_clear;
   logic [AW-1:0]     st_rd_addr;
   logic [DVW-1:0]    quotient;
   logic              div_done, div_start;
   logic [NCW-1:0]    divisor;

   logic accept, slot_free;

   // cell decode
   logic           in_range, active;
   logic [31:0]    s_new, f_new;
   logic [1:0]     seen_new;
   logic           is_hit, is_miss, is_bad;
   logic [SW:0]    hit_add, miss_add;
   logic [CHW:0]   case_add;
   logic [SW:0]    tw_add;
   logic [55:0]    rss_prod;
   logic [RSW:0]   rss_add;
   logic           rss_ge_nc;
   logic           q_over;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (var_count_ff < 5'd2) begin
         k_eff = 5'd2;
      end else if (var_count_ff > 5'(VAR_LIM)) begin
         k_eff = 5'(VAR_LIM);
      end else begin
         k_eff = var_count_ff;
      end
   end

   always_comb begin
      in_range = {1'b0, idx_ff} < k_eff;
      active   = !miss_ff && in_range;
      s_new    = (seen_ff == 2'd0) ? val_ff : succ_ff;
      f_new    = fail_ff;
      seen_new = seen_ff;
      if (seen_ff == 2'd0) begin
         seen_new = 2'd1;
      end else if (seen_ff == 2'd1 && val_ff != succ_ff) begin
         seen_new = 2'd2;
         f_new    = val_ff;
      end
      is_hit   = val_ff == s_new;
      is_miss  = !is_hit && seen_new == 2'd2 && val_ff == f_new;
      is_bad   = active && !is_hit && !is_miss;
      hit_add  = {1'b0, rd_sums.hit} + (SW+1)'(w_ff);
      miss_add = {1'b0, rd_sums.miss} + (SW+1)'(w_ff);
      case_add = {1'b0, case_hit_ff} + (CHW+1)'(1);
      tw_add   = {1'b0, tw_ff} + (SW+1)'(w_ff);
      rss_prod = 56'(w_ff) * 56'(rsq_ff);
      rss_add  = {1'b0, rss_ff} + (RSW+1)'(rss_prod);
      rss_ge_nc = rss_ff >= RSW'(nc_ff);
      divisor  = nc_ff - rss_ff[NCW-1:0];
      q_over   = |quotient[DVW-1:QW];
   end

   always_comb begin
      wr_sums = rd_sums;
      if (is_hit) begin
         wr_sums.hit = hit_add[SW] ? {SW{1'b1}} : hit_add[SW-1:0];
      end else begin
         wr_sums.miss = miss_add[SW] ? {SW{1'b1}} : miss_add[SW-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cqa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == cqa_pkg::CMD_FINISH) begin
                  state_in = bad_ff ? cqa_pkg::ST_ERR : cqa_pkg::ST_WRD;
               end else if ((req_tuser == cqa_pkg::CMD_CELL ||
                             req_tuser == cqa_pkg::CMD_END) && !bad_ff) begin
                  state_in = cqa_pkg::ST_CELL;
               end
            end
         end
         cqa_pkg::ST_CELL: begin
            if (is_bad || cmd_ff != cqa_pkg::CMD_END) begin
               state_in = cqa_pkg::ST_IDLE;
            end else begin
               state_in = cqa_pkg::ST_SQR;
            end
         end
         cqa_pkg::ST_SQR: state_in = cqa_pkg::ST_RSS;
         cqa_pkg::ST_RSS: state_in = cqa_pkg::ST_IDLE;
         cqa_pkg::ST_WRD: state_in = cqa_pkg::ST_ROW;
         cqa_pkg::ST_ROW: begin
            if (slot_free) begin
               state_in = cqa_pkg::ST_SQ;
            end
         end
         cqa_pkg::ST_SQ: begin
            state_in = (walk_ff + 5'd1 == k_eff) ? cqa_pkg::ST_MA : cqa_pkg::ST_WRD;
         end
         cqa_pkg::ST_MA:  state_in = cqa_pkg::ST_MB;
         cqa_pkg::ST_MB:  state_in = cqa_pkg::ST_NUM;
         cqa_pkg::ST_NUM: state_in = cqa_pkg::ST_CHK;
         cqa_pkg::ST_CHK: state_in = rss_ge_nc ? cqa_pkg::ST_SUM : cqa_pkg::ST_DIV;
         cqa_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = cqa_pkg::ST_SUM;
            end
         end
         cqa_pkg::ST_SUM, cqa_pkg::ST_ERR: begin
            if (slot_free) begin
               state_in = cqa_pkg::ST_IDLE;
            end
         end
         default: state_in = cqa_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      st_rd_en   = 1'b0;
      st_rd_addr = idx_ff[AW-1:0];
      st_wr_en   = 1'b0;
      st_clear   = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         cqa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            st_rd_en   = accept;
            st_rd_addr = req_tdata[AW-1:0];
         end
         cqa_pkg::ST_CELL: st_wr_en = active && !is_bad;
         cqa_pkg::ST_WRD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = walk_ff[AW-1:0];
         end
         cqa_pkg::ST_CHK: div_start = !rss_ge_nc;
         cqa_pkg::ST_SUM, cqa_pkg::ST_ERR: st_clear = slot_free;
         default: st_clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cqa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff <= 5'd2;
      end else if (csr_valid && csr_ready) begin
         var_count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser;
         idx_ff  <= req_tdata[3:0];
         val_ff  <= req_tdata[35:4];
         miss_ff <= req_tdata[36];
         w_ff    <= req_tdata[52:37];
      end
   end

   // accumulated statistics
   always_ff @(posedge clock) begin
      if (reset || st_clear) begin
         succ_ff     <= '0;
         fail_ff     <= '0;
         seen_ff     <= '0;
         case_hit_ff <= '0;
         rss_ff      <= '0;
         tw_ff       <= '0;
         bad_ff      <= 1'b0;
         sat_ff      <= 1'b0;
      end else begin
         case (state_ff)
            cqa_pkg::ST_CELL: begin
               if (active) begin
                  if (is_bad) begin
                     bad_ff <= 1'b1;
                  end else begin
                     succ_ff <= s_new;
                     fail_ff <= f_new;
                     seen_ff <= seen_new;
                     if (is_hit) begin
                        case_hit_ff <= case_add[CHW] ? {CHW{1'b1}} : case_add[CHW-1:0];
                        if (hit_add[SW] || case_add[CHW]) begin
                           sat_ff <= 1'b1;
                        end
                     end else if (miss_add[SW]) begin
                        sat_ff <= 1'b1;
                     end
                  end
               end
            end
            cqa_pkg::ST_RSS: begin
               tw_ff       <= tw_add[SW] ? {SW{1'b1}} : tw_add[SW-1:0];
               rss_ff      <= rss_add[RSW] ? {RSW{1'b1}} : rss_add[RSW-1:0];
               case_hit_ff <= '0;
               if (tw_add[SW] || rss_add[RSW]) begin
                  sat_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // finish datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         cqa_pkg::ST_IDLE: begin
            walk_ff <= '0;
            cl_ff   <= '0;
            cl2_ff  <= '0;
         end
         cqa_pkg::ST_SQR: rsq_ff <= case_hit_ff * case_hit_ff;
         cqa_pkg::ST_ROW: begin
            if (slot_free) begin
               cl_ff <= cl_ff + CLW'(rd_sums.hit);
               sq_ff <= rd_sums.hit * rd_sums.hit;
            end
         end
         cqa_pkg::ST_SQ: begin
            cl2_ff  <= cl2_ff + CL2W'(sq_ff);
            walk_ff <= walk_ff + 5'd1;
         end
         cqa_pkg::ST_MA: a_ff <= AMW'(k_eff) * AMW'(cl2_ff);
         cqa_pkg::ST_MB: b_ff <= BMW'(cl_ff) * BMW'(cl_ff);
         cqa_pkg::ST_NUM: begin
            num_ff <= (a_ff > AMW'(b_ff) ? NMW'(a_ff - AMW'(b_ff)) : '0) *
                      NMW'(k_eff - 5'd1);
            nc_ff  <= NCW'(k_eff) * NCW'(cl_ff);
         end
         cqa_pkg::ST_CHK: undef_ff <= rss_ge_nc;
         default: ;
      endcase
   end

   // result fields for the item being emitted
   always_comb begin
      rsp_data_in = '0;
      case (state_ff)
         cqa_pkg::ST_ROW: begin
            rsp_data_in.row_index  = 4'(walk_ff);
            rsp_data_in.hit_total  = rd_sums.hit;
            rsp_data_in.miss_total = rd_sums.miss;
         end
         cqa_pkg::ST_SUM: begin
            rsp_data_in.success_code = succ_ff;
            rsp_data_in.failure_code = fail_ff;
            rsp_data_in.codes_found  = seen_ff;
            rsp_data_in.weight_sum   = tw_ff;
            rsp_data_in.q_undefined  = undef_ff;
            if (!undef_ff) begin
               rsp_data_in.q_value = q_over ? {QW{1'b1}} : quotient[QW-1:0];
            end
            rsp_data_in.saturated    = sat_ff || (!undef_ff && q_over);
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == cqa_pkg::ST_ROW || state_ff == cqa_pkg::ST_SUM ||
                    state_ff == cqa_pkg::ST_ERR) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         case (state_ff)
            cqa_pkg::ST_ROW: begin
               rsp_data_ff <= rsp_data_in;
               rsp_kind_ff <= cqa_pkg::KIND_ROW;
               rsp_last_ff <= 1'b0;
            end
            cqa_pkg::ST_SUM: begin
               rsp_data_ff <= rsp_data_in;
               rsp_kind_ff <= cqa_pkg::KIND_SUM;
               rsp_last_ff <= 1'b1;
            end
            cqa_pkg::ST_ERR: begin
               rsp_data_ff <= rsp_data_in;
               rsp_kind_ff <= cqa_pkg::KIND_ERR;
               rsp_last_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   cqa_sum_store #(
      .DEPTH (VAR_LIM),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (st_clear),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (rd_sums),
      .wr_en   (st_wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_sums)
   );

   cqa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_ff, {FW{1'b0}}}),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

`ifndef SYNTHESIS
   a_row_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == cqa_pkg::KIND_ROW |-> !rsp_tlast)
      else $error("row item marked last");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cqa_pkg::KIND_ROW |-> rsp_tlast)
      else $error("summary or error item not marked last");

   a_cell_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != cqa_pkg::CMD_FINISH
      |=> !$rose(rsp_tvalid))
      else $error("cell item produced a result");
`endif

endmodule

// File: design/cqa_sum_store.sv
// per-variable hit and miss sums with valid bits and registered read
module cqa_sum_store #(
   parameter int DEPTH = cqa_pkg::VAR_CAP,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output cqa_pkg::sums_type  rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  cqa_pkg::sums_type  wr_data
);

   cqa_pkg::sums_type mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   cqa_pkg::sums_type raw_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written since the last clear reads as zero
   assign rd_data = rd_vld_ff ? raw_ff : '0;

endmodule

// File: design/cqa_divider.sv
// restoring divider, one quotient bit per cycle
module cqa_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cqa_pkg::DIV_W-1:0]  dividend,
   input  logic [cqa_pkg::NC_W-1:0]   divisor,
   output logic [cqa_pkg::DIV_W-1:0]  quotient,
   output logic                       done
);

   localparam int DW = cqa_pkg::DIV_W;
   localparam int RW = cqa_pkg::NC_W;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [RW:0]   shifted;
   logic [RW:0]   diff;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], ge};
         rem_ff <= ge ? diff[RW-1:0] : shifted[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
